>>> rtl/pit_pkg.sv
// Shared types, field widths and codes for the process id table.
`default_nettype none

package pit_pkg;

	// Default table geometry.
	localparam int ID_COUNT_DEF    = 256;
	localparam int MIN_ID_DEF      = 2;
	localparam int HANDLE_BITS_DEF = 16;

	// Request and response field widths.
	localparam int OP_W       = 2;
	localparam int SLOT_W     = 8;
	localparam int HANDLE_W   = 16;
	localparam int STATUS_W   = 2;
	localparam int ASSIGNED_W = 8;
	localparam int HIGH_W     = 8;
	localparam int COUNT_W    = 9;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Request kinds.
	typedef enum logic [OP_W-1:0] {
		OP_GET    = 2'd0,
		OP_SET    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_ADD    = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_UP,
		S_APP,
		S_DN
	} pit_state_t;

	// Datapath actions issued by the controller.
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_ACCEPT,
		ACT_REJECT,
		ACT_GET,
		ACT_SET,
		ACT_REM_MISS,
		ACT_REM_DONE,
		ACT_REM_SCAN,
		ACT_UP_PLACE,
		ACT_UP_NEXT,
		ACT_FULL,
		ACT_APPEND_RD,
		ACT_APPEND,
		ACT_DN_DONE,
		ACT_DN_NEXT
	} pit_act_t;

	typedef struct packed {
		pit_act_t act;
	} pit_cmd_t;

	// Datapath conditions seen by the controller.
	typedef struct packed {
		op_t  op;          // kind of the request in progress
		logic bad;         // id outside the valid range
		logic hit;         // addressed slot is occupied
		logic id_high;     // addressed slot is the highest id
		logic inrow_hit;   // an occupied slot lies below the id in its own row
		logic row_zero;    // scan pointer is at the first row
		logic row_any;     // row under the scan pointer has an occupied slot
		logic free_any;    // row under the scan pointer has a usable free slot
		logic row_last_up; // no free candidates lie beyond the current row
		logic full;        // highest id is at the top of the table
		logic clr_last;    // clearing pass is at its last row
		logic out_free;    // response register can take a new response
	} pit_sts_t;

endpackage

`default_nettype wire

>>> rtl/pit_req_if.sv
// Request channel of the process id table.
`default_nettype none

interface pit_req_if import pit_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [SLOT_W-1:0]   slot_id;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output op, output slot_id, output handle, input ready);
	modport sink (input valid, input op, input slot_id, input handle, output ready);

endinterface

`default_nettype wire

>>> rtl/pit_rsp_if.sv
// Response channel of the process id table.
`default_nettype none

interface pit_rsp_if import pit_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [ASSIGNED_W-1:0] assigned_id;
	logic [HANDLE_W-1:0]   handle_out;
	logic                  found;
	logic [HIGH_W-1:0]     highest_id;
	logic [COUNT_W-1:0]    entry_count;

	modport source (
		output valid, output status, output assigned_id, output handle_out,
		output found, output highest_id, output entry_count, input ready
	);
	modport sink (
		input valid, input status, input assigned_id, input handle_out,
		input found, input highest_id, input entry_count, output ready
	);

endinterface

`default_nettype wire

>>> rtl/process_id_table.sv
// Top level of the process id table: first-free id allocator with get, set, remove and add.
//
//   Channel  Role    Contents
//   req      sink    op, slot_id, handle
//   rsp      source  status, assigned_id, handle_out, found, highest_id, entry_count
//
// Get, set, remove and rejected requests finish in the look state. Add reads one occupancy row
// (32 ids by default) per cycle from the bottom up to the row of the highest id, and may then
// append the id above the highest. Removing the highest id, when no lower occupied id shares
// its row, scans rows downward. After reset a clearing pass writes every occupancy row, one a
// cycle (8 rows by default). A finished request holds while the response register is full.
`default_nettype none

module process_id_table import pit_pkg::*; #(
	parameter int ID_COUNT    = ID_COUNT_DEF,
	parameter int MIN_ID      = MIN_ID_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pit_req_if.sink   req,
	pit_rsp_if.source rsp
);

	pit_cmd_t cmd;
	pit_sts_t sts;
	logic     rdy;

	assign req.ready = rdy;

	// Sequencing of each request.
	pit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (op_t'(req.op)),
		.req_ready (rdy),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Memories, searches and response register.
	pit_dp #(
		.ID_COUNT    (ID_COUNT),
		.MIN_ID      (MIN_ID),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_op      (req.op),
		.req_slot_id (req.slot_id),
		.req_handle  (req.handle),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/pit_ctrl.sv
// Controller state machine of the process id table.
`default_nettype none

module pit_ctrl import pit_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  op_t      req_op,
	output logic     req_ready,
	input  pit_sts_t sts,
	output pit_cmd_t cmd
);

	pit_state_t state_q;
	pit_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath actions.
	always_comb begin
		state_d   = state_q;
		cmd.act   = ACT_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.act = ACT_CLEAR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.act = ACT_ACCEPT;
					state_d = (req_op == OP_ADD) ? S_UP : S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.bad) begin
					if (sts.out_free) begin
						cmd.act = ACT_REJECT;
						state_d = S_IDLE;
					end
				end else begin
					case (sts.op)
						OP_GET: begin
							if (sts.out_free) begin
								cmd.act = ACT_GET;
								state_d = S_IDLE;
							end
						end
						OP_SET: begin
							if (sts.out_free) begin
								cmd.act = ACT_SET;
								state_d = S_IDLE;
							end
						end
						OP_REMOVE: begin
							if (!sts.hit) begin
								if (sts.out_free) begin
									cmd.act = ACT_REM_MISS;
									state_d = S_IDLE;
								end
							end else if (sts.id_high && !sts.inrow_hit && !sts.row_zero) begin
								// The new highest id lies in a lower row.
								cmd.act = ACT_REM_SCAN;
								state_d = S_DN;
							end else if (sts.out_free) begin
								cmd.act = ACT_REM_DONE;
								state_d = S_IDLE;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_UP: begin
				// Upward search for the lowest free slot below the highest id.
				if (sts.free_any) begin
					if (sts.out_free) begin
						cmd.act = ACT_UP_PLACE;
						state_d = S_IDLE;
					end
				end else if (!sts.row_last_up) begin
					cmd.act = ACT_UP_NEXT;
				end else if (sts.full) begin
					if (sts.out_free) begin
						cmd.act = ACT_FULL;
						state_d = S_IDLE;
					end
				end else begin
					cmd.act = ACT_APPEND_RD;
					state_d = S_APP;
				end
			end
			S_APP: begin
				if (sts.out_free) begin
					cmd.act = ACT_APPEND;
					state_d = S_IDLE;
				end
			end
			S_DN: begin
				// Downward search for the new highest id.
				if (sts.row_any || sts.row_zero) begin
					if (sts.out_free) begin
						cmd.act = ACT_DN_DONE;
						state_d = S_IDLE;
					end
				end else begin
					cmd.act = ACT_DN_NEXT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/pit_dp.sv
// Datapath of the process id table: occupancy and handle memories, row scans, response register.
`default_nettype none

module pit_dp import pit_pkg::*; #(
	parameter int ID_COUNT    = ID_COUNT_DEF,
	parameter int MIN_ID      = MIN_ID_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pit_cmd_t            cmd,
	output pit_sts_t            sts,
	input  logic [OP_W-1:0]     req_op,
	input  logic [SLOT_W-1:0]   req_slot_id,
	input  logic [HANDLE_W-1:0] req_handle,
	pit_rsp_if.source           rsp
);

	localparam int IW      = $clog2(ID_COUNT);
	localparam int RW_BITS = (IW - 1 < 5) ? IW - 1 : 5;
	localparam int ROW_W   = 1 << RW_BITS;
	localparam int ROWS    = (ID_COUNT + ROW_W - 1) / ROW_W;
	localparam int RIW     = IW - RW_BITS;
	localparam int CW      = $clog2(ID_COUNT + 1);

	// Memories: one occupancy row per ROW_W ids, one handle per id.
	logic [ROW_W-1:0]       occ_mem [ROWS];
	logic [HANDLE_BITS-1:0] h_mem   [ID_COUNT];
	logic [ROW_W-1:0]       occ_rd_q;
	logic [HANDLE_BITS-1:0] hrd_q;

	// Request in progress.
	op_t                    op_q;
	logic                   bad_q;
	logic [SLOT_W-1:0]      id_q;
	logic [IW-1:0]          idx_q;
	logic [HANDLE_BITS-1:0] hnd_q;

	// Table state and search pointers.
	logic [IW-1:0]          highest_q;
	logic [CW-1:0]          count_q;
	logic [RIW-1:0]         row_q;
	logic [IW-1:0]          tgt_q;

	// Response register.
	logic                   vld_q;
	logic [STATUS_W-1:0]    status_q;
	logic [ASSIGNED_W-1:0]  asg_q;
	logic [HANDLE_W-1:0]    hout_q;
	logic                   fnd_q;
	logic [HIGH_W-1:0]      high_q;
	logic [COUNT_W-1:0]     cnt_q;

	logic [IW-1:0]          acc_idx;
	logic                   acc_bad;
	logic [RW_BITS-1:0]     pos_id;
	logic [RIW-1:0]         row_id;
	logic [ROW_W-1:0]       bit_id;
	logic                   hit;
	logic [ROW_W-1:0]       masked_dn;
	logic [RIW-1:0]         hi_row;
	logic [RW_BITS-1:0]     hi_pos;
	logic [ROW_W-1:0]       up_mask;
	logic [ROW_W-1:0]       free_bits;
	logic [RW_BITS-1:0]     lsb_free;
	logic [RW_BITS-1:0]     msb_dn;
	logic [RW_BITS-1:0]     msb_all;
	logic [RW_BITS-1:0]     tgt_pos;

	logic                   occ_we;
	logic [RIW-1:0]         occ_wa;
	logic [ROW_W-1:0]       occ_wd;
	logic                   occ_re;
	logic [RIW-1:0]         occ_ra;
	logic                   h_we;
	logic [IW-1:0]          h_wa;
	logic [RIW-1:0]         row_d;
	logic [IW-1:0]          tgt_d;
	logic [IW-1:0]          highest_d;
	logic [CW-1:0]          count_d;
	logic                   emit;
	logic [STATUS_W-1:0]    st_d;
	logic [ASSIGNED_W-1:0]  asg_d;
	logic [HANDLE_W-1:0]    hout_d;
	logic                   fnd_d;
	logic                   out_free;

	// Decode of the incoming request.
	assign acc_idx = IW'(req_slot_id);
	assign acc_bad = !((32'(req_slot_id) >= 32'(MIN_ID)) && (32'(req_slot_id) < 32'(ID_COUNT)));

	// Position of the addressed slot within its row.
	assign pos_id    = idx_q[RW_BITS-1:0];
	assign row_id    = idx_q[IW-1:RW_BITS];
	assign bit_id    = ROW_W'(1) << pos_id;
	assign hit       = occ_rd_q[pos_id];
	assign masked_dn = occ_rd_q & (bit_id - ROW_W'(1));
	assign tgt_pos   = tgt_q[RW_BITS-1:0];

	// Candidate window for the free-slot search: ids 1 up to highest-1.
	assign hi_row = highest_q[IW-1:RW_BITS];
	assign hi_pos = highest_q[RW_BITS-1:0];

	always_comb begin
		if (row_q < hi_row) begin
			up_mask = '1;
		end else if (row_q == hi_row) begin
			up_mask = (ROW_W'(1) << hi_pos) - ROW_W'(1);
		end else begin
			up_mask = '0;
		end
		if (row_q == '0) begin
			up_mask[0] = 1'b0;
		end
	end

	assign free_bits = ~occ_rd_q & up_mask;

	// Priority encoders over one row.
	always_comb begin
		lsb_free = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				lsb_free = RW_BITS'(i);
			end
		end
	end

	always_comb begin
		msb_dn  = '0;
		msb_all = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (masked_dn[i]) begin
				msb_dn = RW_BITS'(i);
			end
			if (occ_rd_q[i]) begin
				msb_all = RW_BITS'(i);
			end
		end
	end

	assign out_free = !vld_q || rsp.ready;

	// Conditions for the controller.
	always_comb begin
		sts.op          = op_q;
		sts.bad         = bad_q;
		sts.hit         = hit;
		sts.id_high     = (idx_q == highest_q);
		sts.inrow_hit   = |masked_dn;
		sts.row_zero    = (row_q == '0);
		sts.row_any     = |occ_rd_q;
		sts.free_any    = |free_bits;
		sts.row_last_up = (row_q >= hi_row);
		sts.full        = (highest_q >= IW'(ID_COUNT - 1));
		sts.clr_last    = (row_q == RIW'(ROWS - 1));
		sts.out_free    = out_free;
	end

	// Action decode: memory ports, state updates and response fields.
	always_comb begin
		occ_we    = 1'b0;
		occ_wa    = row_id;
		occ_wd    = occ_rd_q;
		occ_re    = 1'b0;
		occ_ra    = row_q;
		h_we      = 1'b0;
		h_wa      = idx_q;
		row_d     = row_q;
		tgt_d     = tgt_q;
		highest_d = highest_q;
		count_d   = count_q;
		emit      = 1'b0;
		st_d      = ST_OK;
		asg_d     = id_q;
		hout_d    = '0;
		fnd_d     = 1'b0;
		case (cmd.act)
			ACT_CLEAR: begin
				occ_we = 1'b1;
				occ_wa = row_q;
				occ_wd = '0;
				row_d  = row_q + RIW'(1);
			end
			ACT_ACCEPT: begin
				occ_re = 1'b1;
				occ_ra = (op_t'(req_op) == OP_ADD) ? '0 : acc_idx[IW-1:RW_BITS];
				row_d  = occ_ra;
			end
			ACT_REJECT: begin
				emit = 1'b1;
				st_d = ST_RANGE;
			end
			ACT_GET: begin
				emit   = 1'b1;
				fnd_d  = hit;
				hout_d = hit ? HANDLE_W'(hrd_q) : '0;
			end
			ACT_SET: begin
				occ_we    = 1'b1;
				occ_wd    = occ_rd_q | bit_id;
				h_we      = 1'b1;
				count_d   = count_q + CW'(!hit);
				highest_d = (idx_q > highest_q) ? idx_q : highest_q;
				emit      = 1'b1;
				fnd_d     = hit;
			end
			ACT_REM_MISS: begin
				emit = 1'b1;
			end
			ACT_REM_DONE: begin
				occ_we  = 1'b1;
				occ_wd  = occ_rd_q & ~bit_id;
				count_d = count_q - CW'(1);
				if (idx_q == highest_q) begin
					highest_d = sts.inrow_hit ? {row_id, msb_dn} : '0;
				end
				emit    = 1'b1;
				fnd_d   = 1'b1;
				hout_d  = HANDLE_W'(hrd_q);
			end
			ACT_REM_SCAN: begin
				occ_we  = 1'b1;
				occ_wd  = occ_rd_q & ~bit_id;
				count_d = count_q - CW'(1);
				row_d   = row_q - RIW'(1);
				occ_re  = 1'b1;
				occ_ra  = row_d;
			end
			ACT_UP_PLACE: begin
				occ_we  = 1'b1;
				occ_wa  = row_q;
				occ_wd  = occ_rd_q | (ROW_W'(1) << lsb_free);
				h_we    = 1'b1;
				h_wa    = {row_q, lsb_free};
				count_d = count_q + CW'(1);
				emit    = 1'b1;
				asg_d   = ASSIGNED_W'({row_q, lsb_free});
			end
			ACT_UP_NEXT: begin
				row_d  = row_q + RIW'(1);
				occ_re = 1'b1;
				occ_ra = row_d;
			end
			ACT_FULL: begin
				emit  = 1'b1;
				st_d  = ST_FULL;
				asg_d = '0;
			end
			ACT_APPEND_RD: begin
				tgt_d  = highest_q + IW'(1);
				occ_re = 1'b1;
				occ_ra = tgt_d[IW-1:RW_BITS];
			end
			ACT_APPEND: begin
				occ_we    = 1'b1;
				occ_wa    = tgt_q[IW-1:RW_BITS];
				occ_wd    = occ_rd_q | (ROW_W'(1) << tgt_pos);
				h_we      = 1'b1;
				h_wa      = tgt_q;
				count_d   = count_q + CW'(1);
				highest_d = tgt_q;
				emit      = 1'b1;
				asg_d     = ASSIGNED_W'(tgt_q);
			end
			ACT_DN_DONE: begin
				highest_d = sts.row_any ? {row_q, msb_all} : '0;
				emit      = 1'b1;
				fnd_d     = 1'b1;
				hout_d    = HANDLE_W'(hrd_q);
			end
			ACT_DN_NEXT: begin
				row_d  = row_q - RIW'(1);
				occ_re = 1'b1;
				occ_ra = row_d;
			end
			default: begin
			end
		endcase
	end

	// Occupancy memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		if (occ_re) begin
			occ_rd_q <= occ_mem[occ_ra];
		end
	end

	// Handle memory: read when a request is taken, written by set and add.
	always_ff @(posedge clk) begin
		if (h_we) begin
			h_mem[h_wa] <= hnd_q;
		end
		if (cmd.act == ACT_ACCEPT) begin
			hrd_q <= h_mem[acc_idx];
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.act == ACT_ACCEPT) begin
			op_q  <= op_t'(req_op);
			bad_q <= acc_bad;
			id_q  <= req_slot_id;
			idx_q <= acc_idx;
			hnd_q <= HANDLE_BITS'(req_handle);
		end
		tgt_q <= tgt_d;
	end

	// Table state and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q <= '0;
			count_q   <= '0;
			row_q     <= '0;
		end else begin
			highest_q <= highest_d;
			count_q   <= count_d;
			row_q     <= row_d;
		end
	end

	// Response register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (emit) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= st_d;
			asg_q    <= asg_d;
			hout_q   <= hout_d;
			fnd_q    <= fnd_d;
			high_q   <= HIGH_W'(highest_d);
			cnt_q    <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid       = vld_q;
	assign rsp.status      = status_q;
	assign rsp.assigned_id = asg_q;
	assign rsp.handle_out  = hout_q;
	assign rsp.found       = fnd_q;
	assign rsp.highest_id  = high_q;
	assign rsp.entry_count = cnt_q;

endmodule

`default_nettype wire
